// ----- hdl/kdlr_pkg.sv -----
package kdlr_pkg;

  localparam int NUM_KEYS  = 4;
  localparam int LVL_W     = 4;
  localparam int EXT_W     = (NUM_KEYS > LVL_W) ? NUM_KEYS : LVL_W;
  localparam int IDX_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CODE_W    = 3;
  localparam int FILT_W    = 8;
  localparam int LONG_W    = 16;
  localparam int REP_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int Q_DEPTH   = 2;
  localparam int QP_W      = 1;
  localparam int QC_W      = 2;

  localparam logic [FILT_W-1:0] FILTER_RST = FILT_W'(2);
  localparam logic [LONG_W-1:0] LONG_RST   = LONG_W'(100);
  localparam logic [REP_W-1:0]  REPEAT_RST = REP_W'(100);
  localparam logic [LVL_W-1:0]  MASK_RST   = LVL_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER = 2'd0,
    CFG_LONG   = 2'd1,
    CFG_REPEAT = 2'd2,
    CFG_MASK   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_UP   = 2'd0,
    ST_DOWN = 2'd1,
    ST_LONG = 2'd2
  } press_state_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_KEY   = 2'd1,
    BK_FLUSH = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [FILT_W-1:0] filter_ticks;
    logic [LONG_W-1:0] long_ticks;
    logic [REP_W-1:0]  repeat_ticks;
  } timing_t;

  // one classified scan tick at the head of the queue
  typedef struct packed {
    logic                valid;
    logic [NUM_KEYS-1:0] pressed;
  } tick_t;

endpackage

// ----- hdl/kdlr_front.sv -----
module kdlr_front import kdlr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [LVL_W-1:0] in_key_levels,
  input  logic [LVL_W-1:0] active_high_mask,
  input  logic             q_pop,
  output tick_t            q_head
);

  logic [NUM_KEYS-1:0] q_mem_r [Q_DEPTH];
  logic [QP_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]     count_r, count_nxt;
  logic [EXT_W-1:0]    lvl_ext;
  logic [EXT_W-1:0]    mask_ext;
  logic [EXT_W-1:0]    match_ext;
  logic [NUM_KEYS-1:0] pressed;
  logic                push;

  // keys beyond the pin field read level 0 and mask 0, so they count as pressed
  always_comb begin
    lvl_ext   = EXT_W'(in_key_levels);
    mask_ext  = EXT_W'(active_high_mask);
    match_ext = ~(lvl_ext ^ mask_ext);
    pressed   = match_ext[NUM_KEYS-1:0];
  end

  assign in_stall = (count_r == QC_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;

  assign q_head.valid   = (count_r != '0);
  assign q_head.pressed = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= pressed;
    end
  end

endmodule

// ----- hdl/kdlr_back.sv -----
module kdlr_back import kdlr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  timing_t           timing,
  input  tick_t             q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_key_code,
  output logic              out_last_event
);

  back_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt;
  logic [NUM_KEYS-1:0] pressed_r, pressed_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [CODE_W-1:0]   pend_code_r, pend_code_nxt;

  logic [FILT_W-1:0]   deb_r [NUM_KEYS];
  press_state_t        pst_r [NUM_KEYS];
  logic [LONG_W-1:0]   lng_r [NUM_KEYS];
  logic [REP_W-1:0]    rep_r [NUM_KEYS];

  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   out_code_r, out_code_nxt;
  logic                out_last_r, out_last_nxt;

  logic [FILT_W-1:0]   deb_nxt;
  press_state_t        pst_nxt;
  logic [LONG_W-1:0]   lng_nxt;
  logic [REP_W-1:0]    rep_nxt;
  logic                ev;
  logic [LONG_W-1:0]   lng_inc;
  logic [REP_W-1:0]    rep_inc;
  logic [CODE_W-1:0]   cur_code;
  logic                last_key;
  logic                out_free;

  logic                step;
  logic                flush_done;
  logic                push;
  logic [CODE_W-1:0]   push_code;
  logic                push_last;

  assign last_key = (k_r == IDX_W'(NUM_KEYS - 1));
  assign cur_code = CODE_W'({1'b0, k_r} + 1'b1);
  assign out_free = !out_valid_r || !out_stall;

  // per-key debounce, long press and repeat for the key under the sequencer
  always_comb begin
    deb_nxt = deb_r[k_r];
    pst_nxt = pst_r[k_r];
    lng_nxt = lng_r[k_r];
    rep_nxt = rep_r[k_r];
    ev      = 1'b0;
    lng_inc = lng_r[k_r] + 1'b1;
    rep_inc = rep_r[k_r] + 1'b1;
    if (pressed_r[k_r]) begin
      if (deb_r[k_r] < timing.filter_ticks) begin
        deb_nxt = deb_r[k_r] + 1'b1;
      end else begin
        unique case (pst_r[k_r])
          ST_UP: begin
            pst_nxt = ST_DOWN;
          end
          ST_DOWN: begin
            if ((timing.long_ticks != '0) && (lng_r[k_r] < timing.long_ticks)) begin
              lng_nxt = lng_inc;
              if (lng_inc >= timing.long_ticks) begin
                pst_nxt = ST_LONG;
                ev      = 1'b1;
              end
            end
          end
          ST_LONG: begin
            if (timing.repeat_ticks != '0) begin
              rep_nxt = rep_inc;
              if (rep_inc >= timing.repeat_ticks) begin
                rep_nxt = '0;
                ev      = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      if (deb_r[k_r] != '0) begin
        deb_nxt = deb_r[k_r] - 1'b1;
      end else begin
        ev      = (pst_r[k_r] == ST_DOWN);
        pst_nxt = ST_UP;
      end
      lng_nxt = '0;
      rep_nxt = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_head.valid) begin
          state_nxt = BK_KEY;
        end
      end
      BK_KEY: begin
        if (step && last_key) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (flush_done) begin
          state_nxt = q_head.valid ? BK_KEY : BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // outputs: a held event goes out once the next one (or the tick end) is known
  always_comb begin
    q_pop      = 1'b0;
    step       = 1'b0;
    flush_done = 1'b0;
    push       = 1'b0;
    push_code  = pend_code_r;
    push_last  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        q_pop = q_head.valid;
      end
      BK_KEY: begin
        step = !(ev && pend_v_r) || out_free;
        push = step && ev && pend_v_r;
      end
      BK_FLUSH: begin
        flush_done = !pend_v_r || out_free;
        push       = pend_v_r && out_free;
        push_last  = 1'b1;
        q_pop      = flush_done && q_head.valid;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    k_nxt         = k_r;
    pressed_nxt   = pressed_r;
    pend_v_nxt    = pend_v_r;
    pend_code_nxt = pend_code_r;
    if (q_pop) begin
      k_nxt       = '0;
      pressed_nxt = q_head.pressed;
      pend_v_nxt  = 1'b0;
    end else if (flush_done) begin
      pend_v_nxt = 1'b0;
    end else if (step) begin
      if (!last_key) begin
        k_nxt = k_r + 1'b1;
      end
      if (ev) begin
        pend_v_nxt    = 1'b1;
        pend_code_nxt = cur_code;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = push_code;
      out_last_nxt  = push_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      k_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pressed_r   <= pressed_nxt;
    pend_code_r <= pend_code_nxt;
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        deb_r[i] <= FILTER_RST;
        pst_r[i] <= ST_UP;
        lng_r[i] <= '0;
        rep_r[i] <= '0;
      end
    end else if (step) begin
      deb_r[k_r] <= deb_nxt;
      pst_r[k_r] <= pst_nxt;
      lng_r[k_r] <= lng_nxt;
      rep_r[k_r] <= rep_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = out_code_r;
  assign out_last_event = out_last_r;

endmodule

// ----- hdl/key_debounce_long_repeat_top.sv -----
// The key sequencer walks one key per cycle while the output is not stalled, then closes
// the tick's last event in its flush state before it takes the next scan tick.
// An event waits until the next one or the tick end is known; out_last_event marks the last.
// A two-entry tick queue lets in_ take ticks while the sequencer or output is stalled.
// Reset (rst_n low, synchronous): config registers to their defaults, every key up, hold
// and repeat counters clear, debounce counters at FILTER_RST, tick queue and out_ empty.
module key_debounce_long_repeat_top import kdlr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [LVL_W-1:0]     in_key_levels,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CODE_W-1:0]    out_key_code,
  output logic                 out_last_event,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  timing_t          timing_r;
  logic [LVL_W-1:0] mask_r;
  tick_t            q_head;
  logic             q_pop;
  cfg_reg_t         cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.filter_ticks <= FILTER_RST;
      timing_r.long_ticks   <= LONG_RST;
      timing_r.repeat_ticks <= REPEAT_RST;
      mask_r                <= MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_sel)
        CFG_FILTER: timing_r.filter_ticks <= cfg_data[FILT_W-1:0];
        CFG_LONG:   timing_r.long_ticks   <= cfg_data[LONG_W-1:0];
        CFG_REPEAT: timing_r.repeat_ticks <= cfg_data[REP_W-1:0];
        CFG_MASK:   mask_r                <= cfg_data[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  kdlr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_levels    (in_key_levels),
    .active_high_mask (mask_r),
    .q_pop            (q_pop),
    .q_head           (q_head)
  );

  kdlr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .timing         (timing_r),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_code   (out_key_code),
    .out_last_event (out_last_event)
  );

endmodule

// ----- verif/kdlr_event_checker.sv -----
module kdlr_event_checker import kdlr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [LVL_W-1:0]     in_key_levels,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CODE_W-1:0]    out_key_code,
  input  logic                 out_last_event,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } key_event_t;

  key_event_t event_q[$];

  logic [FILT_W-1:0] filt;
  logic [LONG_W-1:0] long_lim;
  logic [REP_W-1:0]  rep_lim;
  logic [LVL_W-1:0]  hi_mask;

  logic [FILT_W-1:0] db_cnt   [NUM_KEYS];
  press_state_t      pst      [NUM_KEYS];
  logic [LONG_W-1:0] hold_cnt [NUM_KEYS];
  logic [REP_W-1:0]  rep_cnt  [NUM_KEYS];

  // one scan tick: walk the keys in order and queue the events they raise
  function automatic void scan_tick(input logic [LVL_W-1:0] levels);
    logic                pressed;
    logic [NUM_KEYS-1:0] fired;
    key_event_t          ev;
    fired = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      // keys past the level field read level 0 against mask 0
      pressed = (k < LVL_W) ? (levels[k] == hi_mask[k]) : 1'b1;
      if (pressed) begin
        if (db_cnt[k] < filt) begin
          db_cnt[k] = db_cnt[k] + 1'b1;
        end else begin
          case (pst[k])
            ST_UP: pst[k] = ST_DOWN;
            ST_DOWN: begin
              if (long_lim != '0 && hold_cnt[k] < long_lim) begin
                hold_cnt[k] = hold_cnt[k] + 1'b1;
                if (hold_cnt[k] >= long_lim) begin
                  pst[k] = ST_LONG;
                  fired[k] = 1'b1;
                end
              end
            end
            ST_LONG: begin
              if (rep_lim != '0) begin
                rep_cnt[k] = rep_cnt[k] + 1'b1;
                if (rep_cnt[k] >= rep_lim) begin
                  rep_cnt[k] = '0;
                  fired[k] = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end else begin
        if (db_cnt[k] != '0) begin
          db_cnt[k] = db_cnt[k] - 1'b1;
        end else begin
          // only a release from plain down reports; long just falls back to up
          fired[k] = (pst[k] == ST_DOWN);
          pst[k] = ST_UP;
        end
        hold_cnt[k] = '0;
        rep_cnt[k] = '0;
      end
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (fired[k]) begin
        ev.code = CODE_W'(k + 1);
        ev.last = ((fired >> (k + 1)) == '0);
        event_q.push_back(ev);
      end
    end
  endfunction

  always @(posedge clk) begin
    key_event_t want;
    if (!rst_n) begin
      filt = FILTER_RST;
      long_lim = LONG_RST;
      rep_lim = REPEAT_RST;
      hi_mask = MASK_RST;
      for (int k = 0; k < NUM_KEYS; k++) begin
        db_cnt[k] = FILTER_RST;
        pst[k] = ST_UP;
        hold_cnt[k] = '0;
        rep_cnt[k] = '0;
      end
      event_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FILTER: filt = cfg_data[FILT_W-1:0];
          CFG_LONG:   long_lim = cfg_data[LONG_W-1:0];
          CFG_REPEAT: rep_lim = cfg_data[REP_W-1:0];
          CFG_MASK:   hi_mask = cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting so a beat never meets its own tick's events
      if (out_valid && !out_stall) begin
        if (event_q.size() == 0) begin
          $error("key_code: no event expected, actual %0d (last_event %0b)",
                 out_key_code, out_last_event);
          fail_count++;
        end else begin
          want = event_q.pop_front();
          if (out_key_code !== want.code) begin
            $error("key_code mismatch: expected %0d, actual %0d", want.code, out_key_code);
            fail_count++;
          end
          if (out_last_event !== want.last) begin
            $error("last_event mismatch: expected %0b, actual %0b", want.last,
                   out_last_event);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        scan_tick(in_key_levels);
    end
    pending = event_q.size();
  end

endmodule

// ----- verif/key_debounce_long_repeat_top_tb.sv -----
module key_debounce_long_repeat_top_tb import kdlr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICKS_TOTAL = 450;
  localparam int QUIET_TAIL  = 60;
  localparam int SETTLE      = 4 * (NUM_KEYS + 2) + 8;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LVL_W-1:0]     in_key_levels = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CODE_W-1:0]    out_key_code;
  logic                 out_last_event;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FILTER;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          ticks_sent = 0;
  bit          quiet = 1'b0;
  int unsigned cycles = 0;

  logic [LVL_W-1:0] mask_now = MASK_RST;
  logic [LVL_W-1:0] held = '0;

  key_debounce_long_repeat_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_levels  (in_key_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_code   (out_key_code),
    .out_last_event (out_last_event),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  kdlr_event_checker event_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_levels  (in_key_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_code   (out_key_code),
    .out_last_event (out_last_event),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // pin levels that make exactly the keys in p read as pressed
  function automatic logic [LVL_W-1:0] pins_for(input logic [LVL_W-1:0] p);
    return ~(p ^ mask_now);
  endfunction

  task automatic send_tick(input logic [LVL_W-1:0] levels);
    in_valid <= 1'b1;
    in_key_levels <= levels;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    if (ticks_sent >= TICKS_TOTAL - QUIET_TAIL)
      quiet = 1'b1;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // wait out every expected event, then let any event-free ticks clear the queue
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper data bits beyond each register's width are junk on purpose
  task automatic configure(input logic [FILT_W-1:0] f, input logic [LONG_W-1:0] l,
                           input logic [REP_W-1:0] r, input logic [LVL_W-1:0] m);
    write_reg(CFG_FILTER, (CFG_DAT_W'($urandom) << FILT_W) | CFG_DAT_W'(f));
    write_reg(CFG_LONG, CFG_DAT_W'(l));
    write_reg(CFG_REPEAT, (CFG_DAT_W'($urandom) << REP_W) | CFG_DAT_W'(r));
    write_reg(CFG_MASK, (CFG_DAT_W'($urandom) << LVL_W) | CFG_DAT_W'(m));
    cfg_valid <= 1'b0;
    mask_now = m;
  endtask

  initial begin
    int          burst;
    logic        stall_now;
    forever begin
      burst = $urandom_range(1, 11);
      stall_now = !quiet && ($urandom_range(0, 2) == 0);
      repeat (burst) begin
        @(posedge clk);
        out_stall <= stall_now;
      end
    end
  end

  initial begin
    int               phase;
    int               phase_len;
    int               seg_left;
    logic [FILT_W-1:0] f;
    logic [LONG_W-1:0] l;
    logic [REP_W-1:0]  r;
    logic [LVL_W-1:0]  m;
    logic [LVL_W-1:0]  levels;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // raw extremes under the reset settings
    send_tick('0);
    send_tick('1);
    settle();

    configure(1, 2, 1, 4'b0101);
    send_tick(pins_for(4'b0000));
    // all four keys: down, then long, then a repeat
    repeat (4) send_tick(pins_for(4'b1111));
    // release from long gives nothing
    repeat (2) send_tick(pins_for(4'b0000));
    // short press and release on two keys
    repeat (2) send_tick(pins_for(4'b0011));
    repeat (2) send_tick(pins_for(4'b0000));
    settle();

    // long detection off: the key sits in down
    configure(1, 0, 1, 4'b0101);
    repeat (3) send_tick(pins_for(4'b1000));
    settle();
    configure(1, 200, 1, 4'b0101);
    repeat (3) send_tick(pins_for(4'b1000));
    settle();
    // long time dropped below the count already held: no long beat, release still reports
    configure(1, 2, 1, 4'b0101);
    send_tick(pins_for(4'b1000));
    repeat (2) send_tick(pins_for(4'b0000));
    settle();

    phase = 0;
    seg_left = 0;
    while (ticks_sent < TICKS_TOTAL) begin
      case (phase)
        0: begin
          f = '1; l = '1; r = '1; m = '1;
        end
        1: begin
          f = '0; l = 1; r = 1; m = '0;
        end
        default: begin
          f = ($urandom_range(0, 3) == 0) ? FILT_W'(0) : FILT_W'($urandom_range(1, 5));
          case ($urandom_range(0, 9))
            0: l = '0;
            1: l = '1;
            default: l = LONG_W'($urandom_range(1, 12));
          endcase
          case ($urandom_range(0, 7))
            0: r = '0;
            1: r = '1;
            default: r = REP_W'($urandom_range(1, 6));
          endcase
          m = LVL_W'($urandom);
        end
      endcase
      configure(f, l, r, m);
      // keys keep their state across the write, so lowered limits get exercised too
      phase_len = (phase == 0) ? 20 : $urandom_range(20, 50);
      for (int t = 0; t < phase_len && ticks_sent < TICKS_TOTAL; t++) begin
        if (seg_left == 0) begin
          held = LVL_W'($urandom);
          seg_left = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(1, 16);
        end
        seg_left--;
        levels = pins_for(held);
        // contact bounce on a few ticks
        if ($urandom_range(0, 7) == 0)
          levels = levels ^ LVL_W'($urandom);
        send_tick(levels);
      end
      settle();
      phase++;
    end

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/kdlr_pkg.sv
hdl/kdlr_front.sv
hdl/kdlr_back.sv
hdl/key_debounce_long_repeat_top.sv
verif/kdlr_event_checker.sv
verif/key_debounce_long_repeat_top_tb.sv
